/* rtl/core/atup_pkg.sv */
// Shared types, character codes and helpers for the ASCII-to-unsigned parser.
package atup_pkg;

    // Scan phase of the current string
    typedef enum logic [2:0] {
        PH_DONE   = 3'd0,
        PH_BLANK  = 3'd1,
        PH_SIGNED = 3'd2,
        PH_ZERO   = 3'd3,
        PH_PREFIX = 3'd4,
        PH_DIGITS = 3'd5
    } t_phase;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NONUM   = 2'd1,
        ST_OVF     = 2'd2,
        ST_BADBASE = 2'd3
    } t_status;

    // Control part of the scan state
    typedef struct packed {
        t_phase     phase;
        logic       overflowed;
        logic       negative;
        logic [5:0] active_base;
    } t_ctrl;

    // Result strobe and status from the step logic
    typedef struct packed {
        logic    emit;
        t_status status;
    } t_emit;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] NO_DIGIT = 8'hFF;

    localparam logic [5:0] MAX_RADIX   = 6'd36;
    localparam logic [5:0] BASE_RESET  = 6'd10;
    localparam logic [5:0] BASE_DEC    = 6'd10;
    localparam logic [5:0] BASE_OCT    = 6'd8;
    localparam logic [5:0] BASE_HEX    = 6'd16;
    localparam logic [5:0] BASE_AUTO   = 6'd0;
    localparam logic [5:0] BASE_ONE    = 6'd1;

    // Digit value of a character, NO_DIGIT when it is not alphanumeric
    function automatic logic [7:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = c - CH_UP_A + 8'd10;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = c - CH_LO_A + 8'd10;
        end
        return d;
    endfunction

endpackage

/* rtl/core/atup_step.sv */
// Per-character next-state and result logic of the parser.
module atup_step #(
    parameter int VALUE_WIDTH  = 32,
    parameter int OFFSET_WIDTH = 16
) (
    input  atup_pkg::t_ctrl          i_ctrl,
    input  logic [VALUE_WIDTH-1:0]   i_acc,
    input  logic [OFFSET_WIDTH-1:0]  i_pos,
    input  logic [7:0]               i_ch,
    input  logic                     i_start,
    input  logic [5:0]               i_base_cfg,
    output atup_pkg::t_ctrl          o_ctrl,
    output logic [VALUE_WIDTH-1:0]   o_acc,
    output logic [OFFSET_WIDTH-1:0]  o_pos,
    output atup_pkg::t_emit          o_emit,
    output logic [VALUE_WIDTH-1:0]   o_value,
    output logic [OFFSET_WIDTH-1:0]  o_offset
);
    import atup_pkg::*;

    localparam int PW = VALUE_WIDTH + 7;

    t_ctrl                   cur;
    logic [VALUE_WIDTH-1:0]  acc_cur;
    logic [OFFSET_WIDTH-1:0] pos_cur;
    logic [5:0]              base_eff;
    logic [7:0]              dig;
    logic                    dig_ok;
    logic [PW-1:0]           prod;
    logic                    prod_ovf;
    logic                    bad_base;
    logic                    is_blank;
    logic                    first;
    logic                    do_acc;
    logic                    do_finish;
    logic                    do_nonum;
    logic                    pos_inc;

    // A start beat restarts the scan with the configured base
    always_comb begin
        if (i_start) begin
            cur.phase       = PH_BLANK;
            cur.overflowed  = 1'b0;
            cur.negative    = 1'b0;
            cur.active_base = i_base_cfg;
            acc_cur         = '0;
            pos_cur         = '0;
        end else begin
            cur     = i_ctrl;
            acc_cur = i_acc;
            pos_cur = i_pos;
        end
    end

    // Base in force for a digit: automatic picks octal after a leading zero
    always_comb begin
        if (cur.active_base == BASE_AUTO) begin
            base_eff = (cur.phase == PH_ZERO) ? BASE_OCT : BASE_DEC;
        end else begin
            base_eff = cur.active_base;
        end
    end

    assign dig      = digit_of(i_ch);
    assign dig_ok   = dig < {2'b00, base_eff};
    assign bad_base = (cur.active_base == BASE_ONE) || (cur.active_base > MAX_RADIX);
    assign is_blank = (i_ch == CH_SPACE) || (i_ch >= CH_TAB && i_ch <= CH_CR);

    // Multiply-add; anything above the value width is an overflow
    assign prod     = PW'(acc_cur) * PW'(base_eff) + PW'(dig);
    assign prod_ovf = |prod[PW-1:VALUE_WIDTH];

    // Phase decode
    always_comb begin
        first     = 1'b0;
        do_acc    = 1'b0;
        do_finish = 1'b0;
        do_nonum  = 1'b0;
        pos_inc   = 1'b1;
        o_ctrl    = cur;
        o_acc     = acc_cur;
        o_emit    = '{emit: 1'b0, status: ST_OK};
        o_value   = '0;
        o_offset  = '0;

        case (cur.phase)
            PH_BLANK: begin
                if (is_blank) begin
                    o_ctrl.phase = PH_BLANK;
                end else if (i_ch == CH_MINUS || i_ch == CH_PLUS) begin
                    o_ctrl.negative = (i_ch == CH_MINUS);
                    o_ctrl.phase    = PH_SIGNED;
                end else begin
                    first = 1'b1;
                end
            end
            PH_SIGNED: begin
                first = 1'b1;
            end
            PH_ZERO: begin
                if (i_ch == CH_LO_X || i_ch == CH_UP_X) begin
                    o_ctrl.active_base = BASE_HEX;
                    o_ctrl.phase       = PH_PREFIX;
                end else begin
                    o_ctrl.active_base = base_eff;
                    do_acc             = dig_ok;
                    do_finish          = !dig_ok;
                end
            end
            PH_PREFIX: begin
                do_acc   = dig_ok;
                do_nonum = !dig_ok;
            end
            PH_DIGITS: begin
                do_acc    = dig_ok;
                do_finish = !dig_ok;
            end
            default: begin
                pos_inc = 1'b0;
            end
        endcase

        // First significant character: base check, zero prefix, first digit
        if (first) begin
            if (bad_base) begin
                o_emit       = '{emit: 1'b1, status: ST_BADBASE};
                o_ctrl.phase = PH_DONE;
            end else if ((cur.active_base == BASE_AUTO || cur.active_base == BASE_HEX)
                         && i_ch == CH_ZERO) begin
                o_ctrl.phase = PH_ZERO;
            end else begin
                o_ctrl.active_base = base_eff;
                do_acc             = dig_ok;
                do_nonum           = !dig_ok;
            end
        end

        // Digit accumulate; once overflowed the digits are only consumed
        if (do_acc) begin
            o_ctrl.phase = PH_DIGITS;
            if (cur.overflowed || prod_ovf) begin
                o_ctrl.overflowed = 1'b1;
            end else begin
                o_acc = prod[VALUE_WIDTH-1:0];
            end
        end

        if (do_nonum) begin
            o_emit       = '{emit: 1'b1, status: ST_NONUM};
            o_ctrl.phase = PH_DONE;
        end

        // Stop character ends a number
        if (do_finish) begin
            o_ctrl.phase = PH_DONE;
            o_offset     = pos_cur;
            if (cur.overflowed) begin
                o_emit  = '{emit: 1'b1, status: ST_OVF};
                o_value = '1;
            end else begin
                o_emit  = '{emit: 1'b1, status: ST_OK};
                o_value = cur.negative ? (VALUE_WIDTH'(0) - acc_cur) : acc_cur;
            end
        end
    end

    // Saturating character offset
    assign o_pos = (pos_inc && pos_cur != '1) ? pos_cur + OFFSET_WIDTH'(1) : pos_cur;

endmodule

/* rtl/core/ascii_to_unsigned_parser.sv */
// Top level of the streaming ASCII-to-unsigned (strtoul style) parser.
// Takes one character beat per clock while the result slot is free or draining, and
// gives one result beat at the character that stops each string's scan. Throughput is
// one character per cycle under that condition, set by the accumulator loop (one
// VALUE_WIDTH by 6 bit multiply-add and overflow check); a beat passes the input
// register, then the result register, on its way to the result beat. i_start_req
// marks the first character of a string and abandons any string in progress. The
// base register is sampled when a string starts; write it only between strings. No
// result is given for characters that arrive while no string is open.
module ascii_to_unsigned_parser #(
    parameter int VALUE_WIDTH  = 32,
    parameter int OFFSET_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [5:0]              i_number_base,
    // character beats
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [7:0]              i_ch,
    input  logic                    i_start_req,
    // result beats
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [VALUE_WIDTH-1:0]  o_value,
    output logic [OFFSET_WIDTH-1:0] o_end_offset,
    output logic [1:0]              o_status
);
    import atup_pkg::*;

    logic [5:0]              r_base;
    logic                    r_in_valid;
    logic [7:0]              r_ch;
    logic                    r_start;
    t_ctrl                   r_ctrl;
    logic [VALUE_WIDTH-1:0]  r_acc;
    logic [OFFSET_WIDTH-1:0] r_pos;
    logic                    r_out_valid;
    logic [VALUE_WIDTH-1:0]  r_value;
    logic [OFFSET_WIDTH-1:0] r_offset;
    t_status                 r_status;

    t_ctrl                   n_ctrl;
    logic [VALUE_WIDTH-1:0]  n_acc;
    logic [OFFSET_WIDTH-1:0] n_pos;
    t_emit                   n_emit;
    logic [VALUE_WIDTH-1:0]  n_value;
    logic [OFFSET_WIDTH-1:0] n_offset;

    logic                    w_adv;
    logic                    w_fire;

    // Result slot is free or drains this cycle
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    // Base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_valid) begin
            r_base <= i_number_base;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ch    <= i_ch;
            r_start <= i_start_req;
        end
    end

    atup_step #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_step (
        .i_ctrl     (r_ctrl),
        .i_acc      (r_acc),
        .i_pos      (r_pos),
        .i_ch       (r_ch),
        .i_start    (r_start),
        .i_base_cfg (r_base),
        .o_ctrl     (n_ctrl),
        .o_acc      (n_acc),
        .o_pos      (n_pos),
        .o_emit     (n_emit),
        .o_value    (n_value),
        .o_offset   (n_offset)
    );

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '{phase: PH_DONE, overflowed: 1'b0, negative: 1'b0,
                        active_base: BASE_AUTO};
            r_acc  <= '0;
            r_pos  <= '0;
        end else if (w_fire) begin
            r_ctrl <= n_ctrl;
            r_acc  <= n_acc;
            r_pos  <= n_pos;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire && n_emit.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_emit.emit) begin
            r_value  <= n_value;
            r_offset <= n_offset;
            r_status <= n_emit.status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = r_value;
    assign o_end_offset = r_offset;
    assign o_status     = r_status;

`ifndef SYNTHESIS
    // No-number and bad-base results carry zero value and offset
    a_nonum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_NONUM || r_status == ST_BADBASE))
        |-> (r_value == '0 && r_offset == '0))
        else $error("no-number result with nonzero value or offset");

    // Overflow results saturate
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_OVF) |-> (r_value == '1))
        else $error("overflow result not saturated");

    // Overflow only arises while reading digits
    a_ovf_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.overflowed |-> (r_ctrl.phase == PH_DIGITS || r_ctrl.phase == PH_DONE))
        else $error("overflow flag set outside digit phase");

    // After 0x the base is hex
    a_prefix_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctrl.phase == PH_PREFIX) |-> (r_ctrl.active_base == BASE_HEX))
        else $error("prefix phase with non-hex base");

    // A leading zero is only special in automatic or hex base
    a_zero_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctrl.phase == PH_ZERO)
        |-> (r_ctrl.active_base == BASE_AUTO || r_ctrl.active_base == BASE_HEX))
        else $error("leading-zero phase with unexpected base");
`endif

endmodule

/* verif/tb_ascii_to_unsigned_parser.sv */
// Testbench for the streaming ASCII-to-unsigned parser: directed and random strings.
module tb_ascii_to_unsigned_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import atup_pkg::*;

    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         PHASE_CHARS   = 120;
    localparam int         NUM_PHASES    = 12;
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [5:0] BASE_WIDEST   = 6'd36;
    localparam logic [5:0] BASE_BIN      = 6'd2;
    localparam logic [5:0] BASE_TOP      = 6'd63;
    localparam logic [5:0] BASE_PAST_MAX = 6'd37;

    // Radix per random phase; the second to last entry is swapped for a random valid radix
    localparam logic [5:0] PHASE_BASES [NUM_PHASES] = '{
        BASE_DEC, BASE_AUTO, BASE_HEX, BASE_BIN, BASE_WIDEST, BASE_OCT,
        BASE_ONE, BASE_AUTO, BASE_TOP, BASE_PAST_MAX, BASE_DEC, BASE_DEC
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       start;
    } t_char_beat;

    typedef struct packed {
        logic [31:0] value;
        logic [15:0] offset;
        t_status     status;
    } t_conversion;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [5:0]  cfg_base = BASE_RESET;
    logic        in_valid = 1'b0;
    logic [7:0]  in_ch = 8'h00;
    logic        in_start = 1'b0;
    logic        out_ready = 1'b0;
    wire         cfg_ready;
    wire         in_ready;
    wire         out_valid;
    wire  [31:0] out_value;
    wire  [15:0] out_offset;
    wire  [1:0]  out_status;

    ascii_to_unsigned_parser dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_number_base(cfg_base),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_ch         (in_ch),
        .i_start_req  (in_start),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_value      (out_value),
        .o_end_offset (out_offset),
        .o_status     (out_status)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    t_char_beat  char_queue [$];
    t_conversion expected_numbers [$];
    t_conversion want;
    int          error_count = 0;
    int          cycle_count = 0;
    int          phase_chars = 0;

    // Parser shadow state
    logic [5:0]  base_reg = BASE_RESET;
    t_phase      scan_phase = PH_DONE;
    logic [31:0] acc = '0;
    logic        ovf = 1'b0;
    logic        neg = 1'b0;
    logic [5:0]  base_now = '0;
    logic [15:0] pos = '0;

    // Sender and receiver pacing
    logic        send_idle = 1'b1;
    int          burst_left = 0;
    int          gap_left = 0;
    int          rx_mode = 0;
    int          rx_mode_left = 0;
    int          rx_hold_left = 0;
    int          rx_since_hold = 0;

    task automatic flag_error(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // ---------------- conversion predictor ----------------

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return c - CH_ZERO;
        end
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            return c - CH_UP_A + 8'd10;
        end
        if (c >= CH_LO_A && c <= CH_LO_Z) begin
            return c - CH_LO_A + 8'd10;
        end
        return NO_DIGIT;
    endfunction

    function automatic void post_result(input logic [31:0] v, input logic [15:0] off,
                                        input t_status st);
        expected_numbers.push_back('{value: v, offset: off, status: st});
        scan_phase = PH_DONE;
    endfunction

    // Multiply-add with saturation detect; once overflowed, digits are swallowed
    function automatic void add_digit(input logic [7:0] d);
        logic [31:0] b;
        logic [31:0] lim;
        logic [31:0] rem;
        b = {26'd0, base_now};
        if (b < 2) begin
            b = 2;
        end
        lim = 32'hFFFF_FFFF / b;
        rem = 32'hFFFF_FFFF % b;
        if (ovf) begin
            return;
        end
        if (acc < lim || (acc == lim && {24'd0, d} <= rem)) begin
            acc = acc * b + {24'd0, d};
        end else begin
            ovf = 1'b1;
        end
    endfunction

    function automatic void close_number();
        if (ovf) begin
            post_result(32'hFFFF_FFFF, pos, ST_OVF);
        end else if (neg) begin
            post_result(32'd0 - acc, pos, ST_OK);
        end else begin
            post_result(acc, pos, ST_OK);
        end
    endfunction

    function automatic void digit_or_close(input logic [7:0] c);
        logic [7:0] d;
        d = digit_value(c);
        if (d < {2'b00, base_now}) begin
            add_digit(d);
            scan_phase = PH_DIGITS;
        end else begin
            close_number();
        end
    endfunction

    // First character after blanks and sign: base check, leading zero, first digit
    function automatic void first_digit(input logic [7:0] c);
        logic [7:0] d;
        if (base_now == BASE_ONE || base_now > MAX_RADIX) begin
            post_result('0, '0, ST_BADBASE);
        end else if ((base_now == BASE_AUTO || base_now == BASE_HEX) && c == CH_ZERO) begin
            scan_phase = PH_ZERO;
        end else begin
            if (base_now == BASE_AUTO) begin
                base_now = BASE_DEC;
            end
            d = digit_value(c);
            if (d < {2'b00, base_now}) begin
                add_digit(d);
                scan_phase = PH_DIGITS;
            end else begin
                post_result('0, '0, ST_NONUM);
            end
        end
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic s);
        if (s) begin
            scan_phase = PH_BLANK;
            acc        = '0;
            ovf        = 1'b0;
            neg        = 1'b0;
            base_now   = base_reg;
            pos        = '0;
        end
        if (scan_phase == PH_DONE) begin
            return;
        end
        case (scan_phase)
            PH_BLANK: begin
                if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                    if (c == CH_MINUS || c == CH_PLUS) begin
                        neg        = (c == CH_MINUS);
                        scan_phase = PH_SIGNED;
                    end else begin
                        first_digit(c);
                    end
                end
            end
            PH_SIGNED: first_digit(c);
            PH_ZERO: begin
                if (c == CH_LO_X || c == CH_UP_X) begin
                    base_now   = BASE_HEX;
                    scan_phase = PH_PREFIX;
                end else begin
                    if (base_now == BASE_AUTO) begin
                        base_now = BASE_OCT;
                    end
                    digit_or_close(c);
                end
            end
            PH_PREFIX: begin
                if (digit_value(c) < 8'd16) begin
                    add_digit(digit_value(c));
                    scan_phase = PH_DIGITS;
                end else begin
                    post_result('0, '0, ST_NONUM);
                end
            end
            PH_DIGITS: digit_or_close(c);
            default: ;
        endcase
        if (pos != 16'hFFFF) begin
            pos = pos + 16'd1;
        end
    endfunction

    // ---------------- character driver ----------------

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ascii_to_unsigned_parser test failed");
            $finish;
        end
    end

    // Sends beats from char_queue in bursts, predicting each beat on acceptance
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                parse_char(char_queue[0].ch, char_queue[0].start);
                void'(char_queue.pop_front());
            end
            if (in_valid && !in_ready) begin
                // holding the current beat
            end else if (gap_left != 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (char_queue.size() != 0) begin
                in_valid <= 1'b1;
                in_ch    <= char_queue[0].ch;
                in_start <= char_queue[0].start;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = send_idle ? $urandom_range(1, 6) : 0;
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------- result receiver and checker ----------------

    // Stall pattern switches among four random modes; a long hold-off now and then
    always @(posedge clk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end else if (rx_since_hold > 1500 && char_queue.size() > 40) begin
            rx_hold_left  = 250;
            rx_since_hold = 0;
            out_ready <= 1'b0;
        end else begin
            rx_since_hold++;
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 80);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 1) == 1);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (cycle_count[2:0] != 3'b000);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_numbers.size() == 0) begin
                flag_error($sformatf("unexpected result beat value=%h offset=%0d status=%0d",
                                     out_value, out_offset, out_status));
            end else begin
                want = expected_numbers.pop_front();
                if (out_value !== want.value) begin
                    flag_error($sformatf("value %h, expected %h", out_value, want.value));
                end
                if (out_offset !== want.offset) begin
                    flag_error($sformatf("end_offset %0d, expected %0d",
                                         out_offset, want.offset));
                end
                if (out_status !== want.status) begin
                    flag_error($sformatf("status %0d, expected %0d", out_status, want.status));
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic queue_char(input logic [7:0] c, input logic s);
        char_queue.push_back('{ch: c, start: s});
        phase_chars++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            queue_char(s[i], i == 0);
        end
    endtask

    function automatic logic [7:0] char_for_digit(input int v);
        if (v < 10) begin
            return CH_ZERO + 8'(v);
        end
        return (($urandom_range(0, 1) == 1) ? CH_UP_A : CH_LO_A) + 8'(v - 10);
    endfunction

    // One string: mostly well formed for radix b, sometimes raw noise
    task automatic queue_random_string(input logic [5:0] b);
        int         n;
        int         r;
        int         eff;
        logic       lead;
        logic [7:0] c;
        lead = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                queue_char(8'($urandom_range(0, 255)), (i == 0) || ($urandom_range(0, 7) == 0));
            end
            return;
        end
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(0, 3) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
            queue_char(c, lead);
            lead = 1'b0;
        end
        r = $urandom_range(0, 3);
        if (r < 2) begin
            queue_char((r == 0) ? CH_MINUS : CH_PLUS, lead);
            lead = 1'b0;
        end
        eff = (b == BASE_AUTO || b == BASE_ONE || b > MAX_RADIX) ? 10 : int'(b);
        if ((b == BASE_AUTO || b == BASE_HEX) && $urandom_range(0, 2) == 0) begin
            queue_char(CH_ZERO, lead);
            lead = 1'b0;
            if ($urandom_range(0, 2) != 0) begin
                queue_char(($urandom_range(0, 1) == 1) ? CH_UP_X : CH_LO_X, 1'b0);
                eff = 16;
            end else if (b == BASE_AUTO) begin
                eff = 8;
            end
        end
        r = $urandom_range(0, 19);
        n = (r == 0) ? 0 : (r <= 3) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            queue_char(char_for_digit($urandom_range(0, eff - 1)), lead);
            lead = 1'b0;
        end
        r = $urandom_range(0, 7);
        if (r == 0) begin
            // left open: the next string restarts over it
            return;
        end
        if (r == 1) begin
            c = CH_NUL;
        end else begin
            do begin
                c = 8'($urandom_range(0, 255));
            end while (digit_value(c) < 8'(eff));
        end
        queue_char(c, lead);
        // characters between strings are dropped by the block
        if ($urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++) begin
                char_queue.push_back('{ch: 8'($urandom_range(0, 255)), start: 1'b0});
            end
        end
    endtask

    task automatic wait_idle();
        while (char_queue.size() != 0 || in_valid || expected_numbers.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [5:0] b);
        cfg_valid <= 1'b1;
        cfg_base  <= b;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        base_reg = b;
    endtask

    initial begin
        logic [5:0] b;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset radix, idle byte, all-ones byte, blanks/sign/NUL, restart
        char_queue.push_back('{ch: 8'hFF, start: 1'b0});
        queue_char(8'hFF, 1'b1);
        queue_text(" -7");
        queue_char(CH_NUL, 1'b0);
        queue_text("9");
        queue_char(CH_PLUS, 1'b1);
        queue_text("5,");
        queue_char(CH_UP_A, 1'b0);
        wait_idle();

        // Automatic radix: bare prefix, lone leading zero
        write_base(BASE_AUTO);
        queue_text("0x!");
        queue_text("0;");
        wait_idle();

        // Widest radix saturates after seven digits
        write_base(BASE_WIDEST);
        queue_text("zzzzzzz ");
        wait_idle();

        write_base(BASE_ONE);
        queue_text("a");

        // Random phases, one radix each
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            b = (p == 10) ? 6'($urandom_range(2, 36)) : PHASE_BASES[p];
            write_base(b);
            send_idle   = (p % 3 != 1);
            phase_chars = 0;
            while (phase_chars < PHASE_CHARS) begin
                queue_random_string(b);
            end
            // closing string gives a result at once, leaving the block idle
            queue_char(CH_BANG, 1'b1);
        end
        wait_idle();

        if (expected_numbers.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", expected_numbers.size()));
        end
        if (error_count == 0) begin
            $display("ascii_to_unsigned_parser test passed");
        end else begin
            $display("ascii_to_unsigned_parser test failed");
        end
        $finish;
    end

endmodule

/* ascii_to_unsigned_parser.f */
rtl/core/atup_pkg.sv
rtl/core/atup_step.sv
rtl/core/ascii_to_unsigned_parser.sv
verif/tb_ascii_to_unsigned_parser.sv
